// ----- hdl/thi_pkg.sv -----
// Package for the timestamped history interpolator.
// Holds the entry layout, action and status codes and the sequencer states.
// No dependencies.
package thi_pkg;

    // Action codes carried in the input tuser
    localparam logic [1:0] ACT_RECORD = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_TRUNC  = 2'd2;

    // Status codes carried in the output tuser
    localparam logic [2:0] ST_RECORDED = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_INTERP   = 3'd2;
    localparam logic [2:0] ST_CLAMPED  = 3'd3;
    localparam logic [2:0] ST_UNCHANGED = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;
    localparam logic [2:0] ST_TRUNCATED = 3'd6;
    localparam logic [2:0] ST_REJECTED = 3'd7;

    localparam int unsigned CAP_W       = 9;
    localparam int unsigned ALPHA_W     = 16;
    localparam int unsigned ENTRY_W     = 136;

    // One history entry as stored in the RAM word
    typedef struct packed {
        logic [7:0]  mode;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
        logic [31:0] tm;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_Q_OLD,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_LO_RD,
        S_HI_RD,
        S_HI_CAP,
        S_DIV,
        S_MUL,
        S_SUM,
        S_TR_RD,
        S_TR_CHK,
        S_DONE
    } t_state;

endpackage

// ----- hdl/thi_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module thi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/timestamped_history_interpolator.sv -----
// Timestamped history interpolator: keeps up to capacity (timestamp, x, y, z, mode) entries in
// one RAM ring, oldest to newest, and answers record, query and truncate beats with one result
// beat each. A record, an empty-history query or an unknown action needs no RAM read. A
// truncate does one RAM read per removed entry beyond the first, and one more for the entry
// that stops the walk unless the history empties. A query reads the oldest entry; then the
// binary search does one RAM read per step, the two bracket entries are read, the Q0.16 alpha
// comes from a 16-step restoring divider, and a multiply and a sum step follow. A new beat
// is taken only once the previous result sits in the output register, so a stalled result
// beat adds its stall to the next item. No clearing pass.
module timestamped_history_interpolator
    import thi_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [8:0]     i_cfg_wdata,     // capacity
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [135:0]   i_s_tdata,       // time_req, in_x, in_y, in_z, in_mode
    input  logic [1:0]     i_s_tuser,       // action
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [119:0]   o_m_tdata,       // out_x, out_y, out_z, out_mode, fill, zero pad
    output logic [2:0]     o_m_tuser        // status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > CAP_W) ? CW : CAP_W;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] idx);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(idx);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_oldest, n_oldest;
    logic [31:0]     r_newest, n_newest;
    logic [31:0]     r_t, n_t;
    logic [CW-1:0]   r_lo, n_lo, r_hi, n_hi;
    t_entry          r_old, n_old, r_new, n_new;
    logic [31:0]     r_rem, n_rem, r_den, n_den;
    logic [15:0]     r_q, n_q, r_alpha, n_alpha;
    logic [3:0]      r_dcnt, n_dcnt;
    logic signed [49:0] r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic [2:0]      r_status, n_status;
    logic [31:0]     r_rx, n_rx, r_ry, n_ry, r_rz, n_rz;
    logic [7:0]      r_rmode, n_rmode;
    logic [CAP_W-1:0] r_cap;
    logic            r_ovalid;
    logic [2:0]      r_ostatus;
    logic [119:0]    r_odata;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    t_entry          ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rword;

    logic            s_acc, o_load;
    logic [31:0]     in_t;
    logic [WW-1:0]   eff_cap, count_ext;
    logic [CW:0]     mid_sum;
    logic [CW-1:0]   mid;

    thi_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rword)
    );
    assign ram_rdata = t_entry'(ram_rword);

    assign s_acc      = i_s_tvalid && (r_state == S_IDLE);
    assign o_s_tready = (r_state == S_IDLE);
    assign in_t       = i_s_tdata[31:0];
    assign o_load     = (r_state == S_DONE) && (!r_ovalid || i_m_tready);
    assign count_ext  = WW'(r_count);
    assign mid_sum    = (CW+1)'(r_lo) + (CW+1)'(r_hi);
    assign mid        = mid_sum[CW:1];

    // Clamp capacity to 1..DEPTH
    always_comb begin
        eff_cap = WW'(r_cap);
        if (eff_cap == '0) begin
            eff_cap = WW'(1);
        end else if (eff_cap > WW'(DEPTH)) begin
            eff_cap = WW'(DEPTH);
        end
    end

    // Sequencer: next state, RAM access and datapath next values
    always_comb begin
        logic [32:0]        rem2;
        logic [CW-1:0]      lo_x, hi_x;
        logic signed [32:0] dx, dy, dz;
        logic signed [16:0] a17;
        logic signed [49:0] sx, sy, sz;
        n_state  = r_state;
        n_count  = r_count;
        n_oldest = r_oldest;
        n_newest = r_newest;
        n_t      = r_t;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_old    = r_old;
        n_new    = r_new;
        n_rem    = r_rem;
        n_den    = r_den;
        n_q      = r_q;
        n_alpha  = r_alpha;
        n_dcnt   = r_dcnt;
        n_px     = r_px;
        n_py     = r_py;
        n_pz     = r_pz;
        n_status = r_status;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_rz     = r_rz;
        n_rmode  = r_rmode;
        ram_we    = 1'b0;
        ram_waddr = slot_of(r_oldest, r_count);
        ram_wdata = t_entry'({i_s_tdata[135:128], i_s_tdata[127:96], i_s_tdata[95:64],
                              i_s_tdata[63:32], in_t});
        ram_raddr = r_oldest;
        rem2 = '0;
        lo_x = r_lo;
        hi_x = r_hi;
        dx = '0;
        dy = '0;
        dz = '0;
        a17 = '0;
        sx = '0;
        sy = '0;
        sz = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_t     = in_t;
                    n_rx    = '0;
                    n_ry    = '0;
                    n_rz    = '0;
                    n_rmode = '0;
                    n_state = S_DONE;
                    unique case (i_s_tuser)
                        ACT_RECORD: begin
                            if (r_count != '0 && in_t < r_newest) begin
                                n_status = ST_REJECTED;
                            end else begin
                                ram_we   = 1'b1;
                                n_newest = in_t;
                                if (count_ext >= eff_cap) begin
                                    n_oldest = (r_oldest == AW'(DEPTH - 1)) ? '0
                                                                           : r_oldest + 1'b1;
                                    n_status = ST_DROPPED;
                                end else begin
                                    n_count  = r_count + 1'b1;
                                    n_status = ST_RECORDED;
                                end
                            end
                        end
                        ACT_QUERY: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_Q_OLD;
                            end
                        end
                        ACT_TRUNC: begin
                            n_status = ST_TRUNCATED;
                            if (r_count != '0 && r_newest > in_t) begin
                                n_count = r_count - 1'b1;
                                if (r_count != CW'(1)) begin
                                    n_state = S_TR_RD;
                                end
                            end
                        end
                        default: begin
                            n_status = ST_UNCHANGED;
                        end
                    endcase
                end
            end
            S_TR_RD: begin
                ram_raddr = slot_of(r_oldest, r_count - 1'b1);
                n_state   = S_TR_CHK;
            end
            S_TR_CHK: begin
                if (ram_rdata.tm > r_t) begin
                    n_count = r_count - 1'b1;
                    n_state = (r_count == CW'(1)) ? S_DONE : S_TR_RD;
                end else begin
                    n_newest = ram_rdata.tm;
                    n_state  = S_DONE;
                end
            end
            S_Q_OLD: begin
                if (r_t <= ram_rdata.tm) begin
                    n_status = ST_CLAMPED;
                    n_rx     = ram_rdata.x;
                    n_ry     = ram_rdata.y;
                    n_rz     = ram_rdata.z;
                    n_rmode  = ram_rdata.mode;
                    n_state  = S_DONE;
                end else if (r_t >= r_newest) begin
                    n_status = ST_UNCHANGED;
                    n_state  = S_DONE;
                end else begin
                    n_lo    = '0;
                    n_hi    = r_count - 1'b1;
                    n_state = (r_count > CW'(2)) ? S_SRCH_RD : S_LO_RD;
                end
            end
            S_SRCH_RD: begin
                ram_raddr = slot_of(r_oldest, mid);
                n_state   = S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                // Narrow the bracket on the probed timestamp
                if (ram_rdata.tm <= r_t) begin
                    lo_x = mid;
                end else begin
                    hi_x = mid;
                end
                n_lo    = lo_x;
                n_hi    = hi_x;
                n_state = ((CW+1)'(lo_x) + 1'b1 < (CW+1)'(hi_x)) ? S_SRCH_RD : S_LO_RD;
            end
            S_LO_RD: begin
                ram_raddr = slot_of(r_oldest, r_lo);
                n_state   = S_HI_RD;
            end
            S_HI_RD: begin
                ram_raddr = slot_of(r_oldest, r_hi);
                n_old     = ram_rdata;
                n_state   = S_HI_CAP;
            end
            S_HI_CAP: begin
                n_new   = ram_rdata;
                n_rem   = r_t - r_old.tm;
                n_den   = ram_rdata.tm - r_old.tm;
                n_q     = '0;
                n_dcnt  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // One restoring quotient bit per cycle
                rem2 = {r_rem, 1'b0};
                if (rem2 >= {1'b0, r_den}) begin
                    n_rem = 32'(rem2 - {1'b0, r_den});
                    n_q   = {r_q[14:0], 1'b1};
                end else begin
                    n_rem = rem2[31:0];
                    n_q   = {r_q[14:0], 1'b0};
                end
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == 4'hF) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_alpha = (r_den == '0) ? '0 : r_q;
                a17 = $signed({1'b0, n_alpha});
                dx  = $signed({r_new.x[31], r_new.x}) - $signed({r_old.x[31], r_old.x});
                dy  = $signed({r_new.y[31], r_new.y}) - $signed({r_old.y[31], r_old.y});
                dz  = $signed({r_new.z[31], r_new.z}) - $signed({r_old.z[31], r_old.z});
                n_px = dx * a17;
                n_py = dy * a17;
                n_pz = dz * a17;
                n_state = S_SUM;
            end
            S_SUM: begin
                // Round and floor-shift the blend, add to the older position
                sx = (r_px + 50'sd32768) >>> ALPHA_W;
                sy = (r_py + 50'sd32768) >>> ALPHA_W;
                sz = (r_pz + 50'sd32768) >>> ALPHA_W;
                n_rx     = r_old.x + sx[31:0];
                n_ry     = r_old.y + sy[31:0];
                n_rz     = r_old.z + sz[31:0];
                n_rmode  = r_alpha[ALPHA_W-1] ? r_new.mode : r_old.mode;
                n_status = ST_INTERP;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (o_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_oldest <= '0;
            r_cap    <= CAP_W'(256);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_oldest <= n_oldest;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (o_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath and output registers
    always_ff @(posedge i_clk) begin
        r_newest <= n_newest;
        r_t      <= n_t;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_old    <= n_old;
        r_new    <= n_new;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_q      <= n_q;
        r_alpha  <= n_alpha;
        r_dcnt   <= n_dcnt;
        r_px     <= n_px;
        r_py     <= n_py;
        r_pz     <= n_pz;
        r_status <= n_status;
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_rz     <= n_rz;
        r_rmode  <= n_rmode;
        if (o_load) begin
            r_ostatus <= r_status;
            r_odata   <= {7'b0, count_ext[CAP_W-1:0], r_rmode, r_rz, r_ry, r_rx};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ostatus;
    assign o_m_tdata  = r_odata;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_first_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tuser == ACT_RECORD && r_count == '0) |=> (r_count == CW'(1)))
        else $error("record into empty history did not give one entry");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_RD || r_state == S_SRCH_CHK) |-> (r_lo < r_hi))
        else $error("search bracket collapsed");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_den != '0) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");
`endif

endmodule
